// ----- design/kcd_pkg.sv -----
`timescale 1ns / 1ps

package kcd_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int TABLE_AW      = 7;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_KEY      = 2'd1;
  localparam logic [1:0] OP_OTHER    = 2'd2;

  localparam logic [1:0] KIND_ECHO     = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [1:0] TYPED_SAT = 2'd3;

endpackage

// ----- design/keyboard_command_dispatcher.sv -----
`timescale 1ns / 1ps

// Keyboard command dispatcher. One transaction in at a time; every transaction
// ends with an echo of its character (last = 1). Registrations, other messages
// and most keyboard characters go from acceptance straight to the echo load
// and then take the next transaction. A carriage return that raises an error
// notice passes through an error load before the echo. A carriage return that
// closes a capture of n characters passes, after acceptance, through a buffer
// read for the first character, a command table read, a step to register the
// target, then per character a buffer read followed by the output load, and
// finally the echo. The sequencer waits for each buffer read before it loads
// that character. An output stall holds the sequencer in its load state. The
// command table clears at reset through per-entry valid bits, so no clearing
// pass is needed.
module keyboard_command_dispatcher #(
  parameter int MAX_CMD_LEN = 16,
  parameter int ID_WIDTH    = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] key_char,
  input  logic [3:0] sender_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [3:0] target_id,
  output logic [7:0] char_out,
  output logic [3:0] char_index,
  output logic       last
);

  localparam int CNT_W = $clog2(MAX_CMD_LEN + 1);
  localparam int BUF_AW = (MAX_CMD_LEN > 1) ? $clog2(MAX_CMD_LEN) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_TGT  = 3'd3;
  localparam logic [2:0] S_BRD  = 3'd4;
  localparam logic [2:0] S_BOUT = 3'd5;
  localparam logic [2:0] S_ERR  = 3'd6;
  localparam logic [2:0] S_ECHO = 3'd7;

  logic [2:0] state, state_next;
  logic capturing, capturing_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [1:0] typed_count, typed_count_next;
  logic [7:0] char_q;
  logic [kcd_pkg::TABLE_AW-1:0] tbl_addr_q;
  logic [ID_WIDTH-1:0] target_q;
  logic [kcd_pkg::TABLE_ENTRIES-1:0] tbl_valid;

  logic accept, slot_free, load;
  logic [1:0] ld_kind;
  logic [3:0] ld_target;
  logic [7:0] ld_char;
  logic [3:0] ld_index;
  logic ld_last;

  logic buf_we, buf_re;
  logic [BUF_AW-1:0] buf_raddr;
  logic [7:0] buf_rdata;
  logic tbl_we, tbl_re;
  logic [ID_WIDTH-1:0] tbl_wdata, tbl_rdata;
  logic [7:0] sid_wide, tgt_wide, idx_wide;
  logic [CNT_W-1:0] idx_inc;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign sid_wide  = {4'b0000, sender_id};
  assign tbl_wdata = sid_wide[ID_WIDTH-1:0];
  assign tgt_wide  = 8'(target_q);
  assign idx_wide  = 8'(idx);
  assign idx_inc   = CNT_W'(idx + 1'b1);

  kcd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_CMD_LEN),
    .AW   (BUF_AW)
  ) u_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(fill_count[BUF_AW-1:0]),
    .wdata(key_char),
    .re   (buf_re),
    .raddr(buf_raddr),
    .rdata(buf_rdata)
  );

  kcd_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(kcd_pkg::TABLE_ENTRIES),
    .AW   (kcd_pkg::TABLE_AW)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(key_char[kcd_pkg::TABLE_AW-1:0]),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(buf_rdata[kcd_pkg::TABLE_AW-1:0]),
    .rdata(tbl_rdata)
  );

  always_comb begin
    state_next       = state;
    capturing_next   = capturing;
    fill_count_next  = fill_count;
    typed_count_next = typed_count;
    idx_next         = idx;
    buf_we           = 1'b0;
    buf_re           = 1'b0;
    buf_raddr        = '0;
    tbl_we           = 1'b0;
    tbl_re           = 1'b0;
    load             = 1'b0;
    ld_kind          = kcd_pkg::KIND_ECHO;
    ld_target        = 4'd0;
    ld_char          = 8'd0;
    ld_index         = 4'd0;
    ld_last          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_ECHO;
          if (opcode == kcd_pkg::OP_REGISTER) begin
            tbl_we = 1'b1;
          end else if (opcode == kcd_pkg::OP_KEY) begin
            if (!capturing && key_char == kcd_pkg::CH_PERCENT) begin
              capturing_next  = 1'b1;
              fill_count_next = '0;
            end else if (capturing) begin
              if (key_char == kcd_pkg::CH_CR) begin
                if (fill_count != '0) begin
                  state_next = S_RD0;
                end else begin
                  capturing_next = 1'b0;
                end
              end else if (fill_count < CNT_W'(MAX_CMD_LEN)) begin
                buf_we          = 1'b1;
                fill_count_next = CNT_W'(fill_count + 1'b1);
              end
            end else if (key_char == kcd_pkg::CH_CR) begin
              if (typed_count == kcd_pkg::TYPED_SAT) begin
                state_next = S_ERR;
              end
              typed_count_next = 2'd0;
            end else if (typed_count != kcd_pkg::TYPED_SAT) begin
              typed_count_next = 2'(typed_count + 1'b1);
            end
          end
        end
      end
      S_RD0: begin
        buf_re     = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        tbl_re     = 1'b1;
        state_next = S_TGT;
      end
      S_TGT: begin
        idx_next   = '0;
        state_next = S_BRD;
      end
      S_BRD: begin
        buf_re     = 1'b1;
        buf_raddr  = idx[BUF_AW-1:0];
        state_next = S_BOUT;
      end
      S_BOUT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_kind   = kcd_pkg::KIND_DISPATCH;
          ld_target = tgt_wide[3:0];
          ld_char   = buf_rdata;
          ld_index  = idx_wide[3:0];
          idx_next  = idx_inc;
          if (idx_inc == fill_count) begin
            fill_count_next = '0;
            capturing_next  = 1'b0;
            state_next      = S_ECHO;
          end else begin
            state_next = S_BRD;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_kind    = kcd_pkg::KIND_ERROR;
          state_next = S_ECHO;
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_kind    = kcd_pkg::KIND_ECHO;
          ld_char    = char_q;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capturing   <= 1'b0;
      fill_count  <= '0;
      typed_count <= 2'd0;
      tbl_valid   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      capturing   <= capturing_next;
      fill_count  <= fill_count_next;
      typed_count <= typed_count_next;
      if (tbl_we) begin
        tbl_valid[key_char[kcd_pkg::TABLE_AW-1:0]] <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      char_q <= key_char;
    end
    if (tbl_re) begin
      tbl_addr_q <= buf_rdata[kcd_pkg::TABLE_AW-1:0];
    end
    if (state == S_TGT) begin
      target_q <= tbl_valid[tbl_addr_q] ? tbl_rdata : '0;
    end
    if (load) begin
      kind       <= ld_kind;
      target_id  <= ld_target;
      char_out   <= ld_char;
      char_index <= ld_index;
      last       <= ld_last;
    end
  end

endmodule

// ----- design/kcd_ram.sv -----
`timescale 1ns / 1ps

module kcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
